[design/proportional_navigation_command_macros.svh]
// assertion helpers shared by the top module and the square root unit
`ifndef PROPORTIONAL_NAVIGATION_COMMAND_MACROS_SVH
`define PROPORTIONAL_NAVIGATION_COMMAND_MACROS_SVH

// same-cycle implication, checked out of reset
`define PNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pnc_pkg.sv]
package pnc_pkg;

  localparam int ANG_W    = 16;
  localparam int VEL_W    = 16;
  localparam int ACCEL_W  = 24;
  localparam int GAIN_W   = 12;
  localparam int INVDT_W  = 16;
  localparam int MAXACC_W = 23;
  localparam int MINSPD_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 23;

  localparam int DIFF_W   = ANG_W + 1;
  localparam int RAD_W    = 32;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int K_W      = GAIN_W + ROOT_W;
  localparam int K2_W     = K_W + INVDT_W;
  localparam int HI_SHIFT = K2_W / 2;

  localparam int A_W      = 29;
  localparam int B_W      = 23;
  localparam int PROD_W   = A_W + B_W;
  localparam int ACC_W    = 62;
  localparam int Q_W      = ACC_W - 16;
  localparam int FRAC_SH  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NAV_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd3;

  localparam logic [GAIN_W-1:0]   NAV_GAIN_RST  = 12'd768;
  localparam logic [INVDT_W-1:0]  INV_DT_RST    = 16'd100;
  localparam logic [MAXACC_W-1:0] MAX_ACCEL_RST = 23'd76800;
  localparam logic [MINSPD_W-1:0] MIN_SPEED_RST = 16'd400;

  // one request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                  start;
    logic                  clear;
    logic                  hi_shift;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } mac_cmd_t;

endpackage

[design/proportional_navigation_command.sv]
// proportional navigation command: each request carries pitch and yaw line-of-sight
// angles (q2.13 rad) and a velocity vector (1/8 m/s); the block answers one result
// with pitch and yaw acceleration commands (1/256 m/s^2) equal to
// floor(nav_gain * speed * (angle - last angle) * inv_dt / 2^16), clamped to
// +-max_accel with the limited flag, where speed is floor(sqrt(vx^2+vy^2+vz^2)).
// below min_speed the commands are zero, too_slow is set and the stored angles are
// kept. a request runs nine operations through the one shared multiply-accumulate
// unit (three when too slow) and the bit-serial square root; in_tready is high only
// between requests, and a finished result waits in the output register while the
// next request is taken. configuration registers are written on cfg_valid, one per
// cycle; the user must write them only while idle, the block does not enforce it.
module proportional_navigation_command (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // los_pitch, los_yaw, vel_x, vel_y, vel_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pitch_accel, yaw_accel
  output logic [1:0]  out_tuser,  // too_slow, limited
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pnc_pkg::CFG_DAT_W-1:0] cfg_data
);

  `include "proportional_navigation_command_macros.svh"

  localparam int AW = pnc_pkg::ANG_W;
  localparam int VW = pnc_pkg::VEL_W;
  localparam int XW = pnc_pkg::ACCEL_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_ROOT  = 5'b00100,
    ST_CLAMP = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // micro-operations issued to the shared multiplier, in program order
  typedef enum logic [3:0] {
    OP_SQX = 4'd0,
    OP_SQY = 4'd1,
    OP_SQZ = 4'd2,
    OP_GK  = 4'd3,
    OP_KI  = 4'd4,
    OP_PL  = 4'd5,
    OP_PH  = 4'd6,
    OP_YL  = 4'd7,
    OP_YH  = 4'd8
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   issued_r, issued_nxt;

  // configuration
  logic [pnc_pkg::GAIN_W-1:0]   nav_gain_r;
  logic [pnc_pkg::INVDT_W-1:0]  inv_dt_r;
  logic [pnc_pkg::MAXACC_W-1:0] max_accel_r;
  logic [pnc_pkg::MINSPD_W-1:0] min_speed_r;

  // request fields and stored angles
  logic signed [AW-1:0] pitch_r, pitch_nxt, yaw_r, yaw_nxt;
  logic signed [VW-1:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic signed [AW-1:0] last_pitch_r, last_pitch_nxt, last_yaw_r, last_yaw_nxt;

  // intermediate results
  logic [pnc_pkg::ROOT_W-1:0] speed_r, speed_nxt;
  logic [pnc_pkg::K_W-1:0]    k_r, k_nxt;
  logic [pnc_pkg::K2_W-1:0]   k2_r, k2_nxt;
  logic signed [XW-1:0]       q_pitch_r, q_pitch_nxt, q_yaw_r, q_yaw_nxt;
  logic                       lim_r, lim_nxt, slow_r, slow_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  // shared units
  pnc_pkg::mac_cmd_t                  cmd;
  logic signed [pnc_pkg::ACC_W-1:0]   acc;
  logic                               mac_done;
  logic                               sqrt_start, sqrt_done;
  logic [pnc_pkg::ROOT_W-1:0]         sqrt_root;

  logic signed [pnc_pkg::DIFF_W-1:0]  diff_p, diff_y, diff_sel;
  logic signed [pnc_pkg::Q_W-1:0]     q_full, mx, q_clamped;
  logic                               q_hi, q_lo;
  logic                               in_req, out_req;

  pnc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc),
    .done  (mac_done)
  );

  pnc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc[pnc_pkg::RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign in_req  = in_tvalid && in_tready;
  assign out_req = out_valid_r && out_tready;

  // angle steps at full width, no wrap
  assign diff_p = {pitch_r[AW-1], pitch_r} - {last_pitch_r[AW-1], last_pitch_r};
  assign diff_y = {yaw_r[AW-1], yaw_r} - {last_yaw_r[AW-1], last_yaw_r};
  assign diff_sel = (op_r == OP_YL || op_r == OP_YH) ? diff_y : diff_p;

  // operand selection for the multiplier
  always_comb begin
    cmd          = '0;
    cmd.start    = (state_r == ST_MUL) && !issued_r;
    case (op_r)
      OP_SQX: begin
        cmd.a     = {{(pnc_pkg::A_W-VW){vx_r[VW-1]}}, vx_r};
        cmd.b     = {{(pnc_pkg::B_W-VW){vx_r[VW-1]}}, vx_r};
        cmd.clear = 1'b1;
      end
      OP_SQY: begin
        cmd.a = {{(pnc_pkg::A_W-VW){vy_r[VW-1]}}, vy_r};
        cmd.b = {{(pnc_pkg::B_W-VW){vy_r[VW-1]}}, vy_r};
      end
      OP_SQZ: begin
        cmd.a = {{(pnc_pkg::A_W-VW){vz_r[VW-1]}}, vz_r};
        cmd.b = {{(pnc_pkg::B_W-VW){vz_r[VW-1]}}, vz_r};
      end
      OP_GK: begin
        cmd.a     = {{(pnc_pkg::A_W-pnc_pkg::GAIN_W){1'b0}}, nav_gain_r};
        cmd.b     = {{(pnc_pkg::B_W-pnc_pkg::ROOT_W){1'b0}}, speed_r};
        cmd.clear = 1'b1;
      end
      OP_KI: begin
        cmd.a     = {{(pnc_pkg::A_W-pnc_pkg::K_W){1'b0}}, k_r};
        cmd.b     = {{(pnc_pkg::B_W-pnc_pkg::INVDT_W){1'b0}}, inv_dt_r};
        cmd.clear = 1'b1;
      end
      OP_PL, OP_YL: begin
        cmd.a     = {{(pnc_pkg::A_W-pnc_pkg::DIFF_W){diff_sel[pnc_pkg::DIFF_W-1]}}, diff_sel};
        cmd.b     = {{(pnc_pkg::B_W-pnc_pkg::HI_SHIFT){1'b0}},
                     k2_r[pnc_pkg::HI_SHIFT-1:0]};
        cmd.clear = 1'b1;
      end
      OP_PH, OP_YH: begin
        cmd.a        = {{(pnc_pkg::A_W-pnc_pkg::DIFF_W){diff_sel[pnc_pkg::DIFF_W-1]}},
                        diff_sel};
        cmd.b        = {{(pnc_pkg::B_W-(pnc_pkg::K2_W-pnc_pkg::HI_SHIFT)){1'b0}},
                        k2_r[pnc_pkg::K2_W-1:pnc_pkg::HI_SHIFT]};
        cmd.hi_shift = 1'b1;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  // floor divide by 2^16, then clamp to +-max_accel
  always_comb begin
    q_full = acc[pnc_pkg::ACC_W-1:pnc_pkg::FRAC_SH];
    mx     = {{(pnc_pkg::Q_W-pnc_pkg::MAXACC_W){1'b0}}, max_accel_r};
    q_hi   = q_full > mx;
    q_lo   = q_full < -mx;
    if (q_hi) begin
      q_clamped = mx;
    end else if (q_lo) begin
      q_clamped = -mx;
    end else begin
      q_clamped = q_full;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    issued_nxt     = issued_r;
    pitch_nxt      = pitch_r;
    yaw_nxt        = yaw_r;
    vx_nxt         = vx_r;
    vy_nxt         = vy_r;
    vz_nxt         = vz_r;
    last_pitch_nxt = last_pitch_r;
    last_yaw_nxt   = last_yaw_r;
    speed_nxt      = speed_r;
    k_nxt          = k_r;
    k2_nxt         = k2_r;
    q_pitch_nxt    = q_pitch_r;
    q_yaw_nxt      = q_yaw_r;
    lim_nxt        = lim_r;
    slow_nxt       = slow_r;
    sqrt_start     = 1'b0;
    out_valid_nxt  = out_req ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          pitch_nxt  = in_tdata[AW-1:0];
          yaw_nxt    = in_tdata[2*AW-1:AW];
          vx_nxt     = in_tdata[2*AW+VW-1:2*AW];
          vy_nxt     = in_tdata[2*AW+2*VW-1:2*AW+VW];
          vz_nxt     = in_tdata[2*AW+3*VW-1:2*AW+2*VW];
          op_nxt     = OP_SQX;
          issued_nxt = 1'b0;
          lim_nxt    = 1'b0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (mac_done) begin
          issued_nxt = 1'b0;
          case (op_r)
            OP_SQX: op_nxt = OP_SQY;
            OP_SQY: op_nxt = OP_SQZ;
            OP_SQZ: begin
              sqrt_start = 1'b1;
              op_nxt     = OP_GK;
              state_nxt  = ST_ROOT;
            end
            OP_GK: begin
              k_nxt  = acc[pnc_pkg::K_W-1:0];
              op_nxt = OP_KI;
            end
            OP_KI: begin
              k2_nxt = acc[pnc_pkg::K2_W-1:0];
              op_nxt = OP_PL;
            end
            OP_PL: op_nxt = OP_PH;
            OP_YL: op_nxt = OP_YH;
            OP_PH, OP_YH: state_nxt = ST_CLAMP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          speed_nxt = sqrt_root;
          if (sqrt_root < min_speed_r) begin
            slow_nxt  = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            slow_nxt  = 1'b0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_CLAMP: begin
        if (q_hi || q_lo) begin
          lim_nxt = 1'b1;
        end
        if (op_r == OP_PH) begin
          q_pitch_nxt = q_clamped[XW-1:0];
          op_nxt      = OP_YL;
          state_nxt   = ST_MUL;
        end else begin
          q_yaw_nxt = q_clamped[XW-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (slow_r) begin
            out_data_nxt = '0;
            out_user_nxt = 2'b01;
          end else begin
            out_data_nxt   = {q_yaw_r, q_pitch_r};
            out_user_nxt   = {lim_r, 1'b0};
            last_pitch_nxt = pitch_r;
            last_yaw_nxt   = yaw_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_SQX;
      issued_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      last_pitch_r <= '0;
      last_yaw_r   <= '0;
      lim_r        <= 1'b0;
      slow_r       <= 1'b0;
      nav_gain_r   <= pnc_pkg::NAV_GAIN_RST;
      inv_dt_r     <= pnc_pkg::INV_DT_RST;
      max_accel_r  <= pnc_pkg::MAX_ACCEL_RST;
      min_speed_r  <= pnc_pkg::MIN_SPEED_RST;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      issued_r     <= issued_nxt;
      out_valid_r  <= out_valid_nxt;
      last_pitch_r <= last_pitch_nxt;
      last_yaw_r   <= last_yaw_nxt;
      lim_r        <= lim_nxt;
      slow_r       <= slow_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pnc_pkg::REG_NAV_GAIN:  nav_gain_r  <= cfg_data[pnc_pkg::GAIN_W-1:0];
          pnc_pkg::REG_INV_DT:    inv_dt_r    <= cfg_data[pnc_pkg::INVDT_W-1:0];
          pnc_pkg::REG_MAX_ACCEL: max_accel_r <= cfg_data[pnc_pkg::MAXACC_W-1:0];
          pnc_pkg::REG_MIN_SPEED: min_speed_r <= cfg_data[pnc_pkg::MINSPD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pitch_r    <= pitch_nxt;
    yaw_r      <= yaw_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    vz_r       <= vz_nxt;
    speed_r    <= speed_nxt;
    k_r        <= k_nxt;
    k2_r       <= k2_nxt;
    q_pitch_r  <= q_pitch_nxt;
    q_yaw_r    <= q_yaw_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PNC_ASSERT_NEXT(a_busy_after_req, in_req, !in_tready, "request taken while busy")
  `PNC_ASSERT_NOW(a_slow_is_zero, out_tvalid && out_tuser[0],
    out_tdata == 48'd0 && !out_tuser[1], "slow result not zeroed")
  `PNC_ASSERT_NOW(a_limit_hits_bound, out_tvalid && out_tuser[1],
    $signed(out_tdata[23:0]) == $signed({1'b0, max_accel_r}) ||
    $signed(out_tdata[23:0]) == -$signed({1'b0, max_accel_r}) ||
    $signed(out_tdata[47:24]) == $signed({1'b0, max_accel_r}) ||
    $signed(out_tdata[47:24]) == -$signed({1'b0, max_accel_r}),
    "limited flag without a command at the bound")

endmodule

[design/pnc_mac.sv]
module pnc_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pnc_pkg::mac_cmd_t                  cmd,
  output logic signed [pnc_pkg::ACC_W-1:0]   acc,
  output logic                               done
);

  localparam int EXT_W = pnc_pkg::ACC_W - pnc_pkg::PROD_W;

  logic signed [pnc_pkg::PROD_W-1:0] prod_r;
  logic                              stage_r, stage_nxt;
  logic                              clr_r, hi_r;
  logic signed [pnc_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                              done_r, done_nxt;
  logic signed [pnc_pkg::ACC_W-1:0]  ext, addend;

  // product stage, registered before the accumulate
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      prod_r <= cmd.a * cmd.b;
      clr_r  <= cmd.clear;
      hi_r   <= cmd.hi_shift;
    end
  end

  always_comb begin
    ext    = {{EXT_W{prod_r[pnc_pkg::PROD_W-1]}}, prod_r};
    addend = hi_r ? (ext <<< pnc_pkg::HI_SHIFT) : ext;
    stage_nxt = cmd.start;
    done_nxt  = stage_r;
    acc_nxt   = acc_r;
    if (stage_r) begin
      acc_nxt = (clr_r ? '0 : acc_r) + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[design/pnc_isqrt.sv]
module pnc_isqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [pnc_pkg::RAD_W-1:0]          radicand,
  output logic                               done,
  output logic [pnc_pkg::ROOT_W-1:0]         root
);

  `include "proportional_navigation_command_macros.svh"

  localparam int REM_W = pnc_pkg::ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(pnc_pkg::ROOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(pnc_pkg::ROOT_W - 1);

  logic [pnc_pkg::RAD_W-1:0]  x_r, x_nxt, rad_r, rad_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [pnc_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic [SH_W-1:0]            rem_sh, trial, diff;
  logic                       ge;

  // one result bit per step: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {rem_r, x_r[pnc_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;

    x_nxt    = x_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = x_r << 2;
      rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_nxt = {root_r[pnc_pkg::ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  `PNC_ASSERT_NOW(a_root_not_high, done_r,
    ({16'd0, root_r} * {16'd0, root_r}) <= rad_r, "square root too large")
  `PNC_ASSERT_NOW(a_root_not_low, done_r,
    ({17'd0, root_r} + 34'd1) * ({17'd0, root_r} + 34'd1) > {2'b00, rad_r},
    "square root too small")
  `PNC_ASSERT_NOW(a_no_restart, start, !busy_r, "square root restarted while busy")

endmodule
